@@ sv/assert_macros.svh @@
// Assertion macros shared by the fmod block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ sv/f32fmod_pkg.sv @@
// Types and constants for the single-precision fmod block.
package f32fmod_pkg;
	localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;
	localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
	localparam logic [31:0] EXP_ALL = 32'h7F80_0000;
	localparam logic [31:0] LINEAR_TOP = 32'h0100_0000;
	localparam logic [31:0] QNAN_OUT = 32'h7FC0_0000;

	typedef enum logic [1:0] {
		JOB_DIRECT = 2'd0, // result known at classify time
		JOB_LINEAR = 2'd1, // tiny divisor, result = remainder pattern
		JOB_NORM = 2'd2    // remainder renormalized on divisor exponent
	} job_kind_t;

	// one classified job handed from front to back
	typedef struct packed {
		job_kind_t kind;
		logic [31:0] direct; // result for JOB_DIRECT
		logic [24:0] m;      // dividend significand (or pattern)
		logic [24:0] b;      // divisor significand (or pattern)
		logic [7:0] d;       // shift count
		logic [7:0] eb;      // divisor exponent
		logic sign;
	} job_t;
endpackage

@@ sv/f32fmod_front.sv @@
// Front end: accepts operand pairs and classifies them into jobs.
module f32fmod_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         x,
	input  logic [31:0]         y,
	output logic                job_valid,
	input  logic                job_ready,
	output f32fmod_pkg::job_t   job
);
	logic [31:0] a, b;
	logic [7:0] ea, eb;
	f32fmod_pkg::job_t cls;
	logic valid_q;
	f32fmod_pkg::job_t job_q;

	assign a = {1'b0, x[30:0]};
	assign b = {1'b0, y[30:0]};
	assign ea = a[30:23];
	assign eb = b[30:23];

	always_comb begin
		cls = '0;
		cls.sign = x[31];
		cls.eb = eb;
		if (a >= f32fmod_pkg::EXP_ALL || b > f32fmod_pkg::EXP_ALL || b == 32'd0) begin
			cls.kind = f32fmod_pkg::JOB_DIRECT;
			cls.direct = f32fmod_pkg::QNAN_OUT;
		end else if (a < b) begin
			cls.kind = f32fmod_pkg::JOB_DIRECT;
			cls.direct = x;
		end else if (b <= f32fmod_pkg::LINEAR_TOP) begin
			cls.kind = f32fmod_pkg::JOB_LINEAR;
			cls.b = b[24:0];
			if (a <= f32fmod_pkg::LINEAR_TOP) begin
				// a <= 2^24, reduce directly with zero shifts
				cls.m = a[24:0];
				cls.d = 8'd0;
			end else begin
				cls.m = {2'b01, a[22:0]};
				cls.d = ea - 8'd1;
			end
		end else begin
			cls.kind = f32fmod_pkg::JOB_NORM;
			cls.m = {2'b01, a[22:0]};
			cls.b = {2'b01, b[22:0]};
			cls.d = ea - eb;
		end
	end

	assign in_ready = !valid_q || job_ready;
	assign job_valid = valid_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_q <= cls;
		end
	end
endmodule

@@ sv/f32fmod_back.sv @@
// Back end: shift-subtract reduction, renormalization and result register.
`include "assert_macros.svh"
module f32fmod_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  f32fmod_pkg::job_t   job,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         res
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SHIFT, ST_NORM, ST_DONE
	} state_t;

	state_t state_q;
	f32fmod_pkg::job_t job_q;
	logic [25:0] r_q;
	logic [24:0] m_q;
	logic [8:0] cnt_q;
	logic [24:0] sig_q;
	logic [4:0] nsh_q;
	logic [31:0] res_q;
	logic out_valid_q;
	logic [25:0] r_sh;
	logic signed [9:0] e_n;
	logic [31:0] sub_res;

	assign job_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign res = res_q;
	// dividend bits enter first (restoring division), then zeros for the shift count
	assign r_sh = {r_q[24:0], m_q[24]};
	assign e_n = $signed({2'b00, job_q.eb}) - $signed({5'b0, nsh_q});
	// subnormal: r << (eb - 1), here eb is at most 23
	assign sub_res = {7'd0, r_q[24:0]} << job_q.eb[4:0] >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						job_q <= job;
						r_q <= 26'd0;
						m_q <= job.m;
						cnt_q <= {1'b0, job.d} + 9'd25;
						state_q <= (job.kind == f32fmod_pkg::JOB_DIRECT) ? ST_DONE : ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (cnt_q == 9'd0) begin
						sig_q <= r_q[24:0];
						nsh_q <= 5'd0;
						state_q <= (job_q.kind == f32fmod_pkg::JOB_NORM) ? ST_NORM : ST_DONE;
					end else begin
						r_q <= (r_sh >= {1'b0, job_q.b}) ? r_sh - {1'b0, job_q.b} : r_sh;
						m_q <= {m_q[23:0], 1'b0};
						cnt_q <= cnt_q - 9'd1;
					end
				end
				ST_NORM: begin
					if (sig_q == 25'd0 || sig_q[23]) begin
						state_q <= ST_DONE;
					end else begin
						sig_q <= {sig_q[23:0], 1'b0};
						nsh_q <= nsh_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						case (job_q.kind)
							f32fmod_pkg::JOB_DIRECT: res_q <= job_q.direct;
							f32fmod_pkg::JOB_LINEAR: res_q <= {job_q.sign, 6'd0, r_q[24:0]};
							f32fmod_pkg::JOB_NORM: begin
								if (sig_q == 25'd0) begin
									res_q <= {job_q.sign, 31'd0};
								end else if (e_n <= 10'sd0) begin
									res_q <= {job_q.sign, sub_res[30:0]};
								end else begin
									res_q <= {job_q.sign, e_n[7:0], sig_q[22:0]};
								end
							end
							default: res_q <= f32fmod_pkg::QNAN_OUT;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_rem_below_div, clk, arst_n, state_q == ST_SHIFT, r_q < 26'(job_q.b))
	`ASSERT_NEXT(a_take_only_idle, clk, arst_n, job_valid && job_ready, state_q != ST_IDLE)
	`ASSERT_IMPLIES(a_norm_kind, clk, arst_n, state_q == ST_NORM, job_q.kind == f32fmod_pkg::JOB_NORM)
endmodule

@@ sv/float32_remainder_fmod.sv @@
// Top level of the single-precision fmod block.
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | numerator_bits[31:0], denominator_bits[63:32]
// m_axis  | out | remainder_bits[31:0]
// The reducer shifts in the 25 dividend significand bits, then runs one
// shift-subtract a cycle over the exponent count d (up to 253).
// A normal remainder is then renormalized; special cases skip the reducer.
// A one-entry queue between classify and reduce lets the next item be accepted
// meanwhile; arst_n clears the valid flags and the reducer state; a stalled
// result holds the reducer.
module float32_remainder_fmod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // numerator_bits, denominator_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // remainder_bits
);
	logic job_valid, job_ready;
	f32fmod_pkg::job_t job;

	f32fmod_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.x(s_axis_tdata[31:0]), .y(s_axis_tdata[63:32]),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	f32fmod_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res(m_axis_tdata)
	);
endmodule
